// File: rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and saturation helper for the SOR Poisson sweep block.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SWEEP = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OMEGA     = 3'd0;
    localparam logic [2:0] CFG_INV_DX_SQ = 3'd1;
    localparam logic [2:0] CFG_INV_DY_SQ = 3'd2;
    localparam logic [2:0] CFG_RELAX     = 3'd3;
    localparam logic [2:0] CFG_COLS      = 3'd4;
    localparam logic [2:0] CFG_ROWS      = 3'd5;
    localparam logic [2:0] CFG_CELLS     = 3'd6;
    localparam logic [2:0] CFG_SIDES     = 3'd7;

    // Bits of the boundary side mask.
    localparam int SIDE_BIT_LEFT   = 0;
    localparam int SIDE_BIT_RIGHT  = 1;
    localparam int SIDE_BIT_BOTTOM = 2;
    localparam int SIDE_BIT_TOP    = 3;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SWEEP,
        CMD_READ,
        CMD_READ_ZERO
    } cmd_kind_t;

    typedef enum logic [3:0] {
        ENG_IDLE,
        ENG_READ,
        ENG_READ_OUT,
        ENG_UPD,
        ENG_RES,
        ENG_RMS_GO,
        ENG_RMS,
        ENG_BND,
        ENG_DONE
    } eng_state_t;

    typedef enum logic [1:0] {
        RMS_IDLE,
        RMS_DIV,
        RMS_SQRT,
        RMS_DONE
    } rms_state_t;

    // Boundary copies run in this order.
    typedef enum logic [1:0] {
        SIDE_BOTTOM,
        SIDE_TOP,
        SIDE_LEFT,
        SIDE_RIGHT
    } side_t;

    typedef struct packed {
        logic [17:0] omega;
        logic [30:0] inv_dx_sq;
        logic [30:0] inv_dy_sq;
        logic [30:0] relax_coeff;
        logic [6:0]  cols;
        logic [6:0]  rows;
        logic [24:0] global_cells;
        logic [3:0]  sides;
    } cfg_t;

    typedef struct packed {
        logic        done;
        logic [30:0] root;
        logic        clamp;
    } rms_res_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               hit;
    } sat_t;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t s;
        s.hit = 1'b1;
        if (v > SAT_HI) begin
            s.val = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            s.val = 32'sh8000_0000;
        end else begin
            s.val = v[31:0];
            s.hit = 1'b0;
        end
        return s;
    endfunction

endpackage

// File: rtl/core/sps_front.sv
// ----------------------------------------------------------------------------
// sps_front
// Accepts input transactions, checks the cell address, computes the grid
// address and queues a command for the engine. Unused ops are dropped.
// ----------------------------------------------------------------------------
module sps_front
    import sps_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    localparam int STRIDE = MAX_ROWS + 2,
    localparam int CELLS  = (MAX_COLS + 2) * STRIDE,
    localparam int AW     = $clog2(CELLS),
    localparam int CMD_W  = 2 + AW + 64
) (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [79:0]      s_tdata,   // col[6:0], row[13:7], pressure_in[45:14],
                                        // rhs_in[77:46], zero pad[79:78]
    input  logic [1:0]       s_tuser,   // op[1:0]
    output logic             push_valid,
    input  logic             push_ready,
    output logic [CMD_W-1:0] push_data
);

    logic [6:0]  col;
    logic [6:0]  row;
    logic        in_range;
    logic        keep;
    cmd_kind_t   kind;
    logic [AW-1:0] addr;

    assign col = s_tdata[6:0];
    assign row = s_tdata[13:7];
    assign in_range = (int'(col) <= MAX_COLS + 1) && (int'(row) <= MAX_ROWS + 1);
    assign addr = in_range ? AW'(int'(col) * STRIDE + int'(row)) : '0;

    always_comb begin
        keep = 1'b0;
        kind = CMD_WRITE;
        case (s_tuser)
            OP_WRITE: begin
                keep = in_range;
                kind = CMD_WRITE;
            end
            OP_SWEEP: begin
                keep = 1'b1;
                kind = CMD_SWEEP;
            end
            OP_READ: begin
                keep = 1'b1;
                kind = in_range ? CMD_READ : CMD_READ_ZERO;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // Dropped transactions are still accepted, they simply never reach the queue.
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && keep;
    assign push_data  = {kind, addr, s_tdata[45:14], s_tdata[77:46]};

endmodule

// File: rtl/core/sps_fifo.sv
// ----------------------------------------------------------------------------
// sps_fifo
// Two-entry command queue between the front end and the engine.
// ----------------------------------------------------------------------------
module sps_fifo
    import sps_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_pop,
    output logic [W-1:0] out_data
);

    localparam int DEPTH = 2;

    logic [W-1:0] entry_reg [DEPTH];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop;

    assign in_ready  = (count_reg != 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: rtl/core/sps_rms.sv
// ----------------------------------------------------------------------------
// sps_rms
// Iterative mean and root: a restoring divide of the 64-bit sum by the cell
// count, one quotient bit a cycle, then a digit-by-digit square root.
// ----------------------------------------------------------------------------
module sps_rms
    import sps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] sum,
    input  logic [24:0] global_cells,
    output rms_res_t    res
);

    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    rms_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [24:0] rem_reg;
    logic [24:0] gc_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [25:0] trial;
    logic        qbit;
    logic [63:0] try_val;
    logic        ge;

    assign trial   = {rem_reg, num_reg[63]};
    assign qbit    = trial >= {1'b0, gc_reg};
    assign try_val = root_reg + bit_reg;
    assign ge      = num_reg >= try_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RMS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        res.done   = 1'b0;
        res.clamp  = 1'b0;
        res.root   = root_reg[30:0];
        case (state_reg)
            RMS_IDLE: begin
                if (start) begin
                    state_next = RMS_DIV;
                end
            end
            RMS_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = RMS_SQRT;
                end
            end
            RMS_SQRT: begin
                if (cnt_reg == SQRT_LAST) begin
                    state_next = RMS_DONE;
                end
            end
            RMS_DONE: begin
                res.done   = 1'b1;
                res.clamp  = |root_reg[63:31];
                if (res.clamp) begin
                    res.root = 31'h7FFF_FFFF;
                end
                state_next = RMS_IDLE;
            end
            default: begin
                state_next = RMS_IDLE;
            end
        endcase
    end

    // num_reg holds the dividend, becomes the quotient, then the radicand.
    always_ff @(posedge aclk) begin
        case (state_reg)
            RMS_IDLE: begin
                cnt_reg  <= '0;
                num_reg  <= sum;
                rem_reg  <= '0;
                gc_reg   <= (global_cells == '0) ? 25'd1 : global_cells;
            end
            RMS_DIV: begin
                num_reg <= {num_reg[62:0], qbit};
                rem_reg <= qbit ? 25'(trial - {1'b0, gc_reg}) : trial[24:0];
                cnt_reg <= (cnt_reg == DIV_LAST) ? '0 : cnt_reg + 6'd1;
                root_reg <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
            end
            RMS_SQRT: begin
                if (ge) begin
                    num_reg  <= num_reg - try_val;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 6'd1;
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule

// File: rtl/core/sps_engine.sv
// ----------------------------------------------------------------------------
// sps_engine
// Back end: owns the pressure and right-hand-side memories, carries out cell
// writes and reads, and sequences the relaxation, residual and boundary passes.
// ----------------------------------------------------------------------------
module sps_engine
    import sps_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    localparam int STRIDE  = MAX_ROWS + 2,
    localparam int CELLS   = (MAX_COLS + 2) * STRIDE,
    localparam int AW      = $clog2(CELLS),
    localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS,
    localparam int IW      = $clog2(MAX_DIM + 2),
    localparam int CMD_W   = 2 + AW + 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             cmd_valid,
    output logic             cmd_pop,
    input  logic [CMD_W-1:0] cmd_data,
    output logic             rms_start,
    output logic [63:0]      rms_sum,
    input  rms_res_t         rms_res,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata    // pressure_out[31:0], residual[62:32],
                                        // saturated[63]
);

    localparam logic [3:0] PH_UPD_LAST = 4'd9;
    localparam logic [3:0] PH_RES_LAST = 4'd10;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] c,
                                                input logic [IW-1:0] r);
        return AW'(int'(c) * STRIDE + int'(r));
    endfunction

    logic signed [31:0] pmem [CELLS];
    logic signed [31:0] rmem [CELLS];

    eng_state_t state_reg, state_next;

    cmd_kind_t          head_kind;
    logic [AW-1:0]      head_addr;
    logic signed [31:0] head_p;
    logic signed [31:0] head_r;

    logic [AW-1:0] cmd_addr_reg;
    logic          zero_reg;

    logic [IW-1:0] nc, nr;
    logic          interior_ok;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic [3:0]    ph_reg;
    side_t         side_reg;
    logic          side_on;
    logic [IW-1:0] side_lim;
    logic          side_done;
    logic          cell_last;
    logic          row_last;

    logic [IW-1:0] mem_c, mem_r;
    logic [AW-1:0] mem_addr;
    logic          p_we, r_we;
    logic signed [31:0] p_wd;
    logic signed [31:0] p_rd_reg, r_rd_reg;

    logic signed [31:0] pe_reg, pw_reg, pn_reg, ps_reg, pc_reg, rs_reg;
    logic signed [32:0] ew_reg, ns_reg;
    logic signed [64:0] mx_reg, my_reg;
    logic signed [50:0] mk_reg;
    logic signed [63:0] mp_reg;
    logic signed [31:0] lap_reg, dxx_reg, dyy_reg, r_reg;
    logic [63:0]        sq_reg, sum_reg;
    logic [30:0]        resid_reg;
    logic               flag_reg;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;

    logic signed [31:0] idx_s, idy_s, relax_s;
    logic signed [18:0] keep_c;
    sat_t               lap_s, newp_s, dxx_s, dyy_s, r_s;
    logic [31:0]        mag;
    logic [64:0]        sum_add;
    logic               out_free;
    logic               out_load;

    assign head_kind = cmd_kind_t'(cmd_data[CMD_W-1 -: 2]);
    assign head_addr = cmd_data[AW+63:64];
    assign head_p    = cmd_data[63:32];
    assign head_r    = cmd_data[31:0];

    assign nc = (int'(cfg.cols) > MAX_COLS) ? IW'(MAX_COLS) : IW'(cfg.cols);
    assign nr = (int'(cfg.rows) > MAX_ROWS) ? IW'(MAX_ROWS) : IW'(cfg.rows);
    assign interior_ok = (nc >= IW'(2)) && (nr >= IW'(2));
    assign row_last  = (j_reg == nr);
    assign cell_last = row_last && (i_reg == nc);

    always_comb begin
        case (side_reg)
            SIDE_BOTTOM: side_on = cfg.sides[SIDE_BIT_BOTTOM];
            SIDE_TOP:    side_on = cfg.sides[SIDE_BIT_TOP];
            SIDE_LEFT:   side_on = cfg.sides[SIDE_BIT_LEFT];
            default:     side_on = cfg.sides[SIDE_BIT_RIGHT];
        endcase
    end
    assign side_lim  = (side_reg == SIDE_BOTTOM || side_reg == SIDE_TOP) ?
                       nc + IW'(1) : nr + IW'(1);
    assign side_done = !side_on || (ph_reg == 4'd1 && k_reg == side_lim);

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign rms_sum  = sum_reg;

    // Arithmetic operands.
    assign idx_s   = signed'({1'b0, cfg.inv_dx_sq});
    assign idy_s   = signed'({1'b0, cfg.inv_dy_sq});
    assign relax_s = signed'({1'b0, cfg.relax_coeff});
    assign keep_c  = 19'sd65536 - signed'({1'b0, cfg.omega});

    assign lap_s  = sat32(66'(mx_reg >>> 16) + 66'(my_reg >>> 16) - 66'(rs_reg));
    assign newp_s = sat32(66'(mk_reg >>> 16) + 66'(mp_reg >>> 16));
    assign dxx_s  = sat32(66'(pe_reg) + 66'(pw_reg) - (66'(pc_reg) <<< 1));
    assign dyy_s  = sat32(66'(pn_reg) + 66'(ps_reg) - (66'(pc_reg) <<< 1));
    assign r_s    = sat32(66'(mx_reg >>> 16) + 66'(my_reg >>> 16) - 66'(rs_reg));
    assign mag    = r_reg[31] ? $unsigned(~r_reg) + 32'd1 : $unsigned(r_reg);
    assign sum_add = {1'b0, sum_reg} + {1'b0, sq_reg};

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        rms_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ENG_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    case (head_kind)
                        CMD_SWEEP: state_next = interior_ok ? ENG_UPD : ENG_RMS_GO;
                        CMD_READ, CMD_READ_ZERO: state_next = ENG_READ;
                        default: state_next = ENG_IDLE;
                    endcase
                end
            end
            ENG_READ: begin
                state_next = ENG_READ_OUT;
            end
            ENG_READ_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ENG_IDLE;
                end
            end
            ENG_UPD: begin
                if (ph_reg == PH_UPD_LAST && cell_last) begin
                    state_next = ENG_RES;
                end
            end
            ENG_RES: begin
                if (ph_reg == PH_RES_LAST && cell_last) begin
                    state_next = ENG_RMS_GO;
                end
            end
            ENG_RMS_GO: begin
                rms_start  = 1'b1;
                state_next = ENG_RMS;
            end
            ENG_RMS: begin
                if (rms_res.done) begin
                    state_next = ENG_BND;
                end
            end
            ENG_BND: begin
                if (side_reg == SIDE_RIGHT && side_done) begin
                    state_next = ENG_DONE;
                end
            end
            ENG_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ENG_IDLE;
                end
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // Memory address: the stencil neighbours east, west, north, south, then
    // the centre; boundary copies read the source in step 0 and write in step 1.
    always_comb begin
        mem_c = i_reg;
        mem_r = j_reg;
        if (state_reg == ENG_BND) begin
            case (side_reg)
                SIDE_BOTTOM: begin
                    mem_c = k_reg;
                    mem_r = (ph_reg == 4'd0) ? IW'(2) : IW'(1);
                end
                SIDE_TOP: begin
                    mem_c = k_reg;
                    mem_r = (ph_reg == 4'd0) ? nr : nr + IW'(1);
                end
                SIDE_LEFT: begin
                    mem_c = (ph_reg == 4'd0) ? IW'(2) : IW'(1);
                    mem_r = k_reg;
                end
                default: begin
                    mem_c = (ph_reg == 4'd0) ? nc : nc + IW'(1);
                    mem_r = k_reg;
                end
            endcase
        end else begin
            case (ph_reg)
                4'd0: mem_c = i_reg + IW'(1);
                4'd1: mem_c = i_reg - IW'(1);
                4'd2: mem_r = j_reg + IW'(1);
                4'd3: mem_r = j_reg - IW'(1);
                default: begin
                    mem_c = i_reg;
                    mem_r = j_reg;
                end
            endcase
        end
    end

    always_comb begin
        if (state_reg == ENG_IDLE) begin
            mem_addr = head_addr;
        end else if (state_reg == ENG_READ || state_reg == ENG_READ_OUT) begin
            mem_addr = cmd_addr_reg;
        end else begin
            mem_addr = cell_addr(mem_c, mem_r);
        end
    end

    assign r_we = (state_reg == ENG_IDLE) && cmd_valid && (head_kind == CMD_WRITE);
    assign p_we = r_we
               || (state_reg == ENG_UPD && ph_reg == PH_UPD_LAST)
               || (state_reg == ENG_BND && ph_reg == 4'd1 && side_on);
    always_comb begin
        if (state_reg == ENG_IDLE) begin
            p_wd = head_p;
        end else if (state_reg == ENG_UPD) begin
            p_wd = newp_s.val;
        end else begin
            p_wd = p_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            pmem[mem_addr] <= p_wd;
        end
        p_rd_reg <= pmem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (r_we) begin
            rmem[mem_addr] <= head_r;
        end
        r_rd_reg <= rmem[mem_addr];
    end

    // Sequencing counters, flag, residual and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg       <= '0;
            i_reg        <= IW'(2);
            j_reg        <= IW'(2);
            k_reg        <= '0;
            side_reg     <= SIDE_BOTTOM;
            sum_reg      <= '0;
            flag_reg     <= 1'b0;
            resid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ENG_IDLE: begin
                    if (cmd_valid && head_kind == CMD_SWEEP) begin
                        flag_reg <= 1'b0;
                        sum_reg  <= '0;
                        ph_reg   <= '0;
                        i_reg    <= IW'(2);
                        j_reg    <= IW'(2);
                    end
                end
                ENG_UPD, ENG_RES: begin
                    if ((state_reg == ENG_UPD && ph_reg == PH_UPD_LAST) ||
                        (state_reg == ENG_RES && ph_reg == PH_RES_LAST)) begin
                        ph_reg <= '0;
                        if (row_last) begin
                            j_reg <= IW'(2);
                            i_reg <= cell_last ? IW'(2) : i_reg + IW'(1);
                        end else begin
                            j_reg <= j_reg + IW'(1);
                        end
                    end else begin
                        ph_reg <= ph_reg + 4'd1;
                    end
                    if (state_reg == ENG_UPD) begin
                        if ((ph_reg == 4'd7 && lap_s.hit) ||
                            (ph_reg == PH_UPD_LAST && newp_s.hit)) begin
                            flag_reg <= 1'b1;
                        end
                    end else begin
                        if ((ph_reg == 4'd6 && (dxx_s.hit || dyy_s.hit)) ||
                            (ph_reg == 4'd8 && r_s.hit)) begin
                            flag_reg <= 1'b1;
                        end
                        if (ph_reg == PH_RES_LAST) begin
                            if (sum_add[64]) begin
                                sum_reg  <= '1;
                                flag_reg <= 1'b1;
                            end else begin
                                sum_reg <= sum_add[63:0];
                            end
                        end
                    end
                end
                ENG_RMS: begin
                    if (rms_res.done) begin
                        resid_reg <= rms_res.root;
                        if (rms_res.clamp) begin
                            flag_reg <= 1'b1;
                        end
                        side_reg <= SIDE_BOTTOM;
                        k_reg    <= '0;
                        ph_reg   <= '0;
                    end
                end
                ENG_BND: begin
                    if (side_done) begin
                        side_reg <= side_t'(side_reg + 2'd1);
                        k_reg    <= '0;
                        ph_reg   <= '0;
                    end else if (ph_reg == 4'd0) begin
                        ph_reg <= 4'd1;
                    end else begin
                        ph_reg <= '0;
                        k_reg  <= k_reg + IW'(1);
                    end
                end
                default: begin
                end
            endcase

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload; a sweep returns zero in the pressure field.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (state_reg == ENG_READ_OUT && !zero_reg) begin
                m_tdata_reg <= {flag_reg, resid_reg, p_rd_reg};
            end else begin
                m_tdata_reg <= {flag_reg, resid_reg, 32'd0};
            end
        end
    end

    // Stencil datapath.
    always_ff @(posedge aclk) begin
        if (state_reg == ENG_IDLE && cmd_valid) begin
            cmd_addr_reg <= head_addr;
            zero_reg     <= (head_kind == CMD_READ_ZERO);
        end
        if (state_reg == ENG_UPD || state_reg == ENG_RES) begin
            case (ph_reg)
                4'd1: pe_reg <= p_rd_reg;
                4'd2: pw_reg <= p_rd_reg;
                4'd3: pn_reg <= p_rd_reg;
                4'd4: begin
                    ps_reg <= p_rd_reg;
                    ew_reg <= 33'(pe_reg) + 33'(pw_reg);
                end
                4'd5: begin
                    pc_reg <= p_rd_reg;
                    rs_reg <= r_rd_reg;
                    ns_reg <= 33'(pn_reg) + 33'(ps_reg);
                    mx_reg <= 65'(ew_reg) * 65'(idx_s);
                end
                default: begin
                end
            endcase
        end
        if (state_reg == ENG_UPD) begin
            case (ph_reg)
                4'd6: begin
                    my_reg <= 65'(ns_reg) * 65'(idy_s);
                    mk_reg <= 51'(keep_c) * 51'(pc_reg);
                end
                4'd7: lap_reg <= lap_s.val;
                4'd8: mp_reg  <= 64'(relax_s) * 64'(lap_reg);
                default: begin
                end
            endcase
        end
        if (state_reg == ENG_RES) begin
            case (ph_reg)
                4'd6: begin
                    dxx_reg <= dxx_s.val;
                    dyy_reg <= dyy_s.val;
                end
                4'd7: begin
                    mx_reg <= 65'(dxx_reg) * 65'(idx_s);
                    my_reg <= 65'(dyy_reg) * 65'(idy_s);
                end
                4'd8: r_reg  <= r_s.val;
                4'd9: sq_reg <= 64'(mag) * 64'(mag);
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/core/sor_poisson_sweep.sv
// A read passes through the command queue, the engine's ENG_READ and ENG_READ_OUT states
// and the output register; a stalled output channel holds the engine in ENG_READ_OUT.
// The engine finishes each command before it takes the next from the queue. It does a
// cell write straight from idle; a sweep runs the relaxation pass over the interior
// cells, the residual pass, the divide and square root, then the boundary copies.
// Reset is synchronous and clears control state only; the grids are undefined
// until written and get no clearing pass.
// ----------------------------------------------------------------------------
// sor_poisson_sweep
// Q16.16 successive over-relaxation sweep of the 2-D Poisson equation with
// RMS residual and Neumann boundary copies, behind a two-entry command queue.
// ----------------------------------------------------------------------------
module sor_poisson_sweep
    import sps_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,    // col[6:0], row[13:7], pressure_in[45:14],
                                    // rhs_in[77:46], zero pad[79:78]
    input  logic [1:0]  s_tuser,    // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata     // pressure_out[31:0], residual[62:32],
                                    // saturated[63]
);

    localparam int STRIDE = MAX_ROWS + 2;
    localparam int CELLS  = (MAX_COLS + 2) * STRIDE;
    localparam int AW     = $clog2(CELLS);
    localparam int CMD_W  = 2 + AW + 64;

    cfg_t cfg_reg;

    logic             push_valid, push_ready;
    logic [CMD_W-1:0] push_data;
    logic             cmd_valid, cmd_pop;
    logic [CMD_W-1:0] cmd_data;
    logic             rms_start;
    logic [63:0]      rms_sum;
    rms_res_t         rms_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.omega        <= 18'd111411;
            cfg_reg.inv_dx_sq    <= 31'd65536;
            cfg_reg.inv_dy_sq    <= 31'd65536;
            cfg_reg.relax_coeff  <= 31'd27853;
            cfg_reg.cols         <= 7'd64;
            cfg_reg.rows         <= 7'd64;
            cfg_reg.global_cells <= 25'd4096;
            cfg_reg.sides        <= 4'hF;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OMEGA:     cfg_reg.omega        <= cfg_data[17:0];
                CFG_INV_DX_SQ: cfg_reg.inv_dx_sq    <= cfg_data;
                CFG_INV_DY_SQ: cfg_reg.inv_dy_sq    <= cfg_data;
                CFG_RELAX:     cfg_reg.relax_coeff  <= cfg_data;
                CFG_COLS:      cfg_reg.cols         <= cfg_data[6:0];
                CFG_ROWS:      cfg_reg.rows         <= cfg_data[6:0];
                CFG_CELLS:     cfg_reg.global_cells <= cfg_data[24:0];
                CFG_SIDES:     cfg_reg.sides        <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    sps_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sps_fifo #(
        .W (CMD_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (cmd_valid),
        .out_pop   (cmd_pop),
        .out_data  (cmd_data)
    );

    sps_rms u_rms (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (rms_start),
        .sum          (rms_sum),
        .global_cells (cfg_reg.global_cells),
        .res          (rms_res)
    );

    sps_engine #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_data),
        .rms_start (rms_start),
        .rms_sum   (rms_sum),
        .rms_res   (rms_res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    // The root unit must divide and then take the root, so done never comes straight after start.
    a_rms_not_immediate: assert property (@(posedge aclk) disable iff (!aresetn)
        rms_start |=> !rms_res.done)
        else $error("root unit finished one cycle after start");

    a_clamp_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rms_res.clamp |-> rms_res.done)
        else $error("root clamp reported without a result");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("engine took a command from an empty queue");

    a_start_not_while_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rms_start |-> !rms_res.done)
        else $error("root unit restarted while delivering a result");
`endif

endmodule

// File: bench/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker
// Watches the configuration port and both stream channels of the SOR Poisson
// sweep block, keeps its own copy of the grids and registers, predicts every
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sps_checker
    import sps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,    // col[6:0], row[13:7], pressure_in[45:14],
                                    // rhs_in[77:46], zero pad[79:78]
    input  logic [1:0]  s_tuser,    // op[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // pressure_out[31:0], residual[62:32],
                                    // saturated[63]
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NC_MAX = 64;
    localparam int NR_MAX = 64;

    typedef struct packed {
        logic [31:0] pressure;
        logic [30:0] residual;
        logic        saturated;
    } sweep_result_t;

    logic signed [31:0] pres_grid [NC_MAX+2][NR_MAX+2];
    logic signed [31:0] src_grid  [NC_MAX+2][NR_MAX+2];
    logic [30:0]        rms_held;
    logic               clamp_seen;
    cfg_t               regs;
    sweep_result_t      awaited [$];

    initial begin
        errors = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint floor16(input longint v);
        return v >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            clamp_seen = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            clamp_seen = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    task automatic relax_grid();
        int nc, nr;
        longint ew, ns, keep, push, c2, sq, mag;
        longint unsigned acc, gc, root;
        logic signed [31:0] lap, dxx, dyy, r;
        nc = (regs.cols > NC_MAX) ? NC_MAX : regs.cols;
        nr = (regs.rows > NR_MAX) ? NR_MAX : regs.rows;
        clamp_seen = 1'b0;
        acc = 0;
        for (int i = 2; i <= nc; i++) begin
            for (int j = 2; j <= nr; j++) begin
                ew = longint'(pres_grid[i+1][j]) + longint'(pres_grid[i-1][j]);
                ns = longint'(pres_grid[i][j+1]) + longint'(pres_grid[i][j-1]);
                lap = clamp32(floor16(ew * longint'(regs.inv_dx_sq))
                              + floor16(ns * longint'(regs.inv_dy_sq))
                              - longint'(src_grid[i][j]));
                keep = floor16((64'sd65536 - longint'(regs.omega))
                               * longint'(pres_grid[i][j]));
                push = floor16(longint'(regs.relax_coeff) * longint'(lap));
                pres_grid[i][j] = clamp32(keep + push);
            end
        end
        for (int i = 2; i <= nc; i++) begin
            for (int j = 2; j <= nr; j++) begin
                c2 = 2 * longint'(pres_grid[i][j]);
                dxx = clamp32(longint'(pres_grid[i+1][j]) - c2 + longint'(pres_grid[i-1][j]));
                dyy = clamp32(longint'(pres_grid[i][j+1]) - c2 + longint'(pres_grid[i][j-1]));
                r = clamp32(floor16(longint'(dxx) * longint'(regs.inv_dx_sq))
                            + floor16(longint'(dyy) * longint'(regs.inv_dy_sq))
                            - longint'(src_grid[i][j]));
                mag = (r < 0) ? -longint'(r) : longint'(r);
                sq = mag * mag;
                if (acc > 64'hFFFF_FFFF_FFFF_FFFF - longint'(unsigned'(sq))) begin
                    acc = 64'hFFFF_FFFF_FFFF_FFFF;
                    clamp_seen = 1'b1;
                end else begin
                    acc += sq;
                end
            end
        end
        gc = (regs.global_cells == 0) ? 1 : regs.global_cells;
        root = int_sqrt(acc / gc);
        if (root > 64'h7FFF_FFFF) begin
            root = 64'h7FFF_FFFF;
            clamp_seen = 1'b1;
        end
        rms_held = root[30:0];
        if (regs.sides[SIDE_BIT_BOTTOM])
            for (int i = 0; i <= nc + 1; i++) pres_grid[i][1] = pres_grid[i][2];
        if (regs.sides[SIDE_BIT_TOP])
            for (int i = 0; i <= nc + 1; i++) pres_grid[i][nr+1] = pres_grid[i][nr];
        if (regs.sides[SIDE_BIT_LEFT])
            for (int j = 0; j <= nr + 1; j++) pres_grid[1][j] = pres_grid[2][j];
        if (regs.sides[SIDE_BIT_RIGHT])
            for (int j = 0; j <= nr + 1; j++) pres_grid[nc+1][j] = pres_grid[nc][j];
    endtask

    always @(posedge aclk) begin
        logic [6:0]    c, r;
        logic          in_range;
        sweep_result_t want;
        if (!aresetn) begin
            awaited.delete();
            rms_held = '0;
            clamp_seen = 1'b0;
            regs = '{omega: 18'd111411, inv_dx_sq: 31'd65536, inv_dy_sq: 31'd65536,
                     relax_coeff: 31'd27853, cols: 7'd64, rows: 7'd64,
                     global_cells: 25'd4096, sides: 4'hF};
            foreach (pres_grid[i, j]) begin
                pres_grid[i][j] = '0;
                src_grid[i][j] = '0;
            end
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = awaited.pop_front();
                    if (m_tdata[31:0] !== want.pressure)
                        report_mismatch("pressure_out", m_tdata[31:0], want.pressure);
                    if (m_tdata[62:32] !== want.residual)
                        report_mismatch("residual", {1'b0, m_tdata[62:32]},
                                        {1'b0, want.residual});
                    if (m_tdata[63] !== want.saturated)
                        report_mismatch("saturated", {31'd0, m_tdata[63]},
                                        {31'd0, want.saturated});
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_OMEGA:     regs.omega        = cfg_data[17:0];
                    CFG_INV_DX_SQ: regs.inv_dx_sq    = cfg_data;
                    CFG_INV_DY_SQ: regs.inv_dy_sq    = cfg_data;
                    CFG_RELAX:     regs.relax_coeff  = cfg_data;
                    CFG_COLS:      regs.cols         = cfg_data[6:0];
                    CFG_ROWS:      regs.rows         = cfg_data[6:0];
                    CFG_CELLS:     regs.global_cells = cfg_data[24:0];
                    CFG_SIDES:     regs.sides        = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                c = s_tdata[6:0];
                r = s_tdata[13:7];
                in_range = (c <= NC_MAX + 1) && (r <= NR_MAX + 1);
                if (s_tuser == OP_WRITE) begin
                    if (in_range) begin
                        pres_grid[c][r] = s_tdata[45:14];
                        src_grid[c][r] = s_tdata[77:46];
                    end
                end else if (s_tuser == OP_SWEEP || s_tuser == OP_READ) begin
                    want.pressure = '0;
                    if (s_tuser == OP_SWEEP)
                        relax_grid();
                    else if (in_range)
                        want.pressure = pres_grid[c][r];
                    want.residual = rms_held;
                    want.saturated = clamp_seen;
                    awaited.push_back(want);
                end
            end
        end
        pending = awaited.size();
    end

    final begin
    end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the SOR Poisson sweep block: fills the whole grid, runs a
// directed set of sweeps and reads over extreme settings, then random phases
// of writes, reads and small sweeps under varying stream back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import sps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          errors;
    int          pending;
    int          idle_pct = 0;
    int          stall_pct = 0;

    always #4 aclk = ~aclk;

    sor_poisson_sweep uut (.*);

    sps_checker chk (.*);

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    always @(negedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= stall_pct);

    // Called and returning at a falling edge.
    task automatic send(input logic [1:0] op, input logic [6:0] c, input logic [6:0] r,
                        input logic [31:0] p, input logic [31:0] q);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {2'b00, q, p, r, c};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    task automatic set_all(input logic [17:0] om, input logic [30:0] dx, input logic [30:0] dy,
                           input logic [30:0] rc, input logic [6:0] nc, input logic [6:0] nr,
                           input logic [24:0] gc, input logic [3:0] sd);
        drain();
        write_reg(CFG_OMEGA, om);
        write_reg(CFG_INV_DX_SQ, dx);
        write_reg(CFG_INV_DY_SQ, dy);
        write_reg(CFG_RELAX, rc);
        write_reg(CFG_COLS, nc);
        write_reg(CFG_ROWS, nr);
        write_reg(CFG_CELLS, gc);
        write_reg(CFG_SIDES, sd);
    endtask

    initial begin
        int kind, ncl, nrw;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Every cell is written once, so no later read or sweep sees an unwritten one.
        for (int c = 0; c <= 65; c++)
            for (int r = 0; r <= 65; r++)
                send(OP_WRITE, c, r, $urandom_range(32'h0001_0000) - 32'h8000,
                     $urandom_range(32'h0000_4000) - 32'h2000);

        // Directed part: reset settings first.
        send(OP_READ, 0, 0, 0, 0);
        send(OP_SWEEP, $urandom, $urandom, 0, 0);
        send(OP_READ, 2, 2, 0, 0);
        send(OP_WRITE, 65, 65, 32'h7FFF_FFFF, 32'h8000_0000);
        send(OP_WRITE, 0, 65, 32'h8000_0000, 32'h7FFF_FFFF);
        send(OP_READ, 65, 65, 0, 0);
        send(OP_READ, 0, 65, 0, 0);
        send(OP_WRITE, 66, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_READ, 66, 3, 0, 0);
        send(OP_READ, 3, 127, 0, 0);
        send(OP_READ, 127, 127, 0, 0);
        send(2'd3, 5, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Extents beyond the grid saturate; zero cell count counts as one.
        set_all(18'd131072, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                7'd127, 7'd127, 25'd0, 4'hF);
        send(OP_SWEEP, 0, 0, 0, 0);
        send(OP_READ, 30, 30, 0, 0);
        set_all(18'd0, 31'd1, 31'd1, 31'd0, 7'd0, 7'd1, 25'h1FF_FFFF, 4'h0);
        send(OP_SWEEP, 0, 0, 0, 0);
        send(OP_READ, 1, 1, 0, 0);
        set_all(18'd65536, 31'd65536, 31'd65536, 31'd16384, 7'd1, 7'd0, 25'd1, 4'hF);
        send(OP_SWEEP, 0, 0, 0, 0);
        send(OP_READ, 0, 1, 0, 0);
        set_all(18'd111411, 31'd65536, 31'd65536, 31'd27853, 7'd4, 7'd3, 25'd6, 4'hA);
        send(OP_SWEEP, 0, 0, 0, 0);
        send(OP_READ, 5, 4, 0, 0);

        // Random phases, each under its own settings, cycling through four pressure mixes.
        for (int ph = 0; ph < 8; ph++) begin
            ncl = $urandom_range(6);
            nrw = $urandom_range(6);
            set_all($urandom_range(131072),
                    ($urandom_range(7) == 0) ? $urandom_range(31'h7FFF_FFFF, 1)
                                             : $urandom_range(262144, 4096),
                    ($urandom_range(7) == 0) ? $urandom_range(31'h7FFF_FFFF, 1)
                                             : $urandom_range(262144, 4096),
                    ($urandom_range(7) == 0) ? $urandom : $urandom_range(65536),
                    ncl, nrw, $urandom_range(64), $urandom_range(15));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            for (int n = 0; n < 200; n++) begin
                if (n == 100 && ph == 2)
                    drain();
                kind = $urandom_range(99);
                if (kind < 55)
                    send(OP_WRITE, $urandom_range(ncl + 1), $urandom_range(nrw + 1),
                         pick_value(), pick_value());
                else if (kind < 80)
                    send(OP_READ, $urandom_range(ncl + 1), $urandom_range(nrw + 1), 0, 0);
                else if (kind < 88)
                    send(OP_SWEEP, $urandom, $urandom, $urandom, $urandom);
                else if (kind < 93)
                    send(OP_READ, $urandom, $urandom, 0, 0);
                else if (kind < 97)
                    send(OP_WRITE, $urandom_range(127, 66), $urandom, $urandom, $urandom);
                else
                    send(2'd3, $urandom, $urandom, $urandom, $urandom);
            end
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
